[rtl/rrgl_pkg.sv]
// ----------------------------------------------------------------------------
// rrgl_pkg
// Shared widths, codes and controller/datapath bundles of the region labeller.
// ----------------------------------------------------------------------------
package rrgl_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int OP_W    = 2;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int RATIO_W = 16;
	localparam int LABEL_W = 13;
	localparam int DIM_W   = 7;
	localparam int THR_W   = 16;
	localparam int MIN_W   = 13;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int PIX_W   = 1 + 3 * RATIO_W;

	localparam logic [LABEL_W-1:0] SAT13 = '1;

	localparam logic [DIM_W-1:0]   RST_ROWS = 7'd64;
	localparam logic [DIM_W-1:0]   RST_COLS = 7'd64;
	localparam logic [THR_W-1:0]   RST_THR  = 16'd256;
	localparam logic [MIN_W-1:0]   RST_MIN  = 13'd0;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_THR  = 2'd2,
		REG_MIN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic acc;
		logic load;
		logic read;
		logic run_start;
		logic clr_step;
		logic scan_rd;
		logic scan_adv;
		logic seed;
		logic nb_rd;
		logic grow;
		logic dir_next;
		logic pop;
		logic pop_ld;
		logic fin;
		logic sweep;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_seed;
		logic scan_last;
		logic nb_ok;
		logic join_ok;
		logic dir_last;
		logic sp_one;
		logic sweep_done;
	} dp_stat_t;

	function automatic logic [RATIO_W-1:0] abs_diff(input logic [RATIO_W-1:0] a,
		input logic [RATIO_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/rrgl_if.sv]
// ----------------------------------------------------------------------------
// rrgl_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface rrgl_in_if;
	logic                        valid;
	logic                        ready;
	logic [rrgl_pkg::OP_W-1:0]    op;
	logic [rrgl_pkg::ROW_W-1:0]   row;
	logic [rrgl_pkg::COL_W-1:0]   col;
	logic                        in_object;
	logic [rrgl_pkg::RATIO_W-1:0] ratio_ch0;
	logic [rrgl_pkg::RATIO_W-1:0] ratio_ch1;
	logic [rrgl_pkg::RATIO_W-1:0] ratio_ch2;

	modport source(output valid, op, row, col, in_object, ratio_ch0, ratio_ch1, ratio_ch2,
		input ready);
	modport sink(input valid, op, row, col, in_object, ratio_ch0, ratio_ch1, ratio_ch2,
		output ready);
endinterface

interface rrgl_out_if;
	logic                        valid;
	logic                        ready;
	logic [rrgl_pkg::LABEL_W-1:0] pixel_label;
	logic [rrgl_pkg::LABEL_W-1:0] labels_issued;
	logic [rrgl_pkg::LABEL_W-1:0] segments_kept;

	modport source(output valid, pixel_label, labels_issued, segments_kept, input ready);
	modport sink(input valid, pixel_label, labels_issued, segments_kept, output ready);
endinterface

[rtl/ratio_region_growing_labeler.sv]
// ----------------------------------------------------------------------------
// ratio_region_growing_labeler
// Load, read and unused beats: result valid the next cycle, one beat per cycle while out_ready
// is high. A run beat clears 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) labels and visited flags,
// then reads and checks each scanned pixel, reads and tests each neighbour inside the tile,
// skips one outside it, pops in a pop and a load step, and sweeps the grown list after each
// seed. The scan end is registered in done_q, which sets out_valid; input is held off
// meanwhile. Reset clears control and counters; labels read as zero until the first run.
// ----------------------------------------------------------------------------
module ratio_region_growing_labeler #(
	parameter int MAX_ROWS = rrgl_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rrgl_pkg::DEF_MAX_COLS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrgl_pkg::APB_AW-1:0] paddr,
	input  logic [rrgl_pkg::APB_DW-1:0] pwdata,
	output logic [rrgl_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	rrgl_in_if.sink                     in_ch,
	rrgl_out_if.source                  out_ch
);

	logic [rrgl_pkg::DIM_W-1:0] tile_rows_q;
	logic [rrgl_pkg::DIM_W-1:0] tile_cols_q;
	logic [rrgl_pkg::THR_W-1:0] thr_q;
	logic [rrgl_pkg::MIN_W-1:0] min_q;
	rrgl_pkg::reg_idx_t         reg_idx;
	logic                       cfg_wr;
	rrgl_pkg::ctrl_cmd_t        cmd;
	rrgl_pkg::dp_stat_t         stat;

	assign pready  = 1'b1;
	assign reg_idx = rrgl_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			rrgl_pkg::REG_ROWS: prdata = rrgl_pkg::APB_DW'(tile_rows_q);
			rrgl_pkg::REG_COLS: prdata = rrgl_pkg::APB_DW'(tile_cols_q);
			rrgl_pkg::REG_THR:  prdata = rrgl_pkg::APB_DW'(thr_q);
			default:            prdata = rrgl_pkg::APB_DW'(min_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_rows_q <= rrgl_pkg::RST_ROWS;
			tile_cols_q <= rrgl_pkg::RST_COLS;
			thr_q       <= rrgl_pkg::RST_THR;
			min_q       <= rrgl_pkg::RST_MIN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rrgl_pkg::REG_ROWS: tile_rows_q <= pwdata[rrgl_pkg::DIM_W-1:0];
				rrgl_pkg::REG_COLS: tile_cols_q <= pwdata[rrgl_pkg::DIM_W-1:0];
				rrgl_pkg::REG_THR:  thr_q       <= pwdata[rrgl_pkg::THR_W-1:0];
				default:            min_q       <= pwdata[rrgl_pkg::MIN_W-1:0];
			endcase
		end
	end

	rrgl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrgl_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.row                (in_ch.row),
		.col                (in_ch.col),
		.in_object          (in_ch.in_object),
		.ratio_ch0          (in_ch.ratio_ch0),
		.ratio_ch1          (in_ch.ratio_ch1),
		.ratio_ch2          (in_ch.ratio_ch2),
		.tile_rows          (tile_rows_q),
		.tile_cols          (tile_cols_q),
		.gradient_threshold (thr_q),
		.min_segment_size   (min_q),
		.pixel_label        (out_ch.pixel_label),
		.labels_issued      (out_ch.labels_issued),
		.segments_kept      (out_ch.segments_kept)
	);

endmodule

[rtl/rrgl_ctrl.sv]
// ----------------------------------------------------------------------------
// rrgl_ctrl
// Sequencer for beat handling, label clear, raster scan, flood search and sweep.
// ----------------------------------------------------------------------------
module rrgl_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [rrgl_pkg::OP_W-1:0] in_op,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  rrgl_pkg::dp_stat_t        stat,
	output rrgl_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_CLEAR    = 10'b00_0000_0010,
		S_SCAN_RD  = 10'b00_0000_0100,
		S_SCAN_CHK = 10'b00_0000_1000,
		S_NB_RD    = 10'b00_0001_0000,
		S_NB_CHK   = 10'b00_0010_0000,
		S_POP      = 10'b00_0100_0000,
		S_POP_LD   = 10'b00_1000_0000,
		S_FIN      = 10'b01_0000_0000,
		S_SWEEP    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   done_q;
	logic   in_acc;

	assign in_ready  = (state_q == S_IDLE) && !done_q && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.acc = 1'b1;
					unique case (in_op)
						rrgl_pkg::OP_LOAD: cmd.load = 1'b1;
						rrgl_pkg::OP_READ: cmd.read = 1'b1;
						rrgl_pkg::OP_RUN: begin
							cmd.run_start = 1'b1;
							state_d       = S_CLEAR;
						end
						default: ;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (stat.scan_seed) begin
					cmd.seed = 1'b1;
					state_d  = S_NB_RD;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = stat.scan_last ? S_IDLE : S_SCAN_RD;
				end
			end
			S_NB_RD: begin
				if (stat.nb_ok) begin
					cmd.nb_rd = 1'b1;
					state_d   = S_NB_CHK;
				end else if (stat.dir_last) begin
					state_d = stat.sp_one ? S_FIN : S_POP;
				end else begin
					cmd.dir_next = 1'b1;
				end
			end
			S_NB_CHK: begin
				if (stat.join_ok) begin
					cmd.grow = 1'b1;
					state_d  = S_NB_RD;
				end else if (stat.dir_last) begin
					state_d = stat.sp_one ? S_FIN : S_POP;
				end else begin
					cmd.dir_next = 1'b1;
					state_d      = S_NB_RD;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_POP_LD;
			end
			S_POP_LD: begin
				cmd.pop_ld = 1'b1;
				state_d    = S_NB_RD;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_done) begin
					cmd.scan_adv = 1'b1;
					state_d      = stat.scan_last ? S_IDLE : S_SCAN_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (cmd.scan_adv && stat.scan_last);
			if (in_acc && (in_op != rrgl_pkg::OP_RUN)) begin
				out_valid_q <= 1'b1;
			end else if (done_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_run_enters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_op == rrgl_pkg::OP_RUN)) |=> (state_q == S_CLEAR))
		else $error("run beat did not start the clear pass");
	a_no_result_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result beat shown while a run is in progress");
`endif

endmodule

[rtl/rrgl_dp.sv]
// ----------------------------------------------------------------------------
// rrgl_dp
// Pixel, label, visited, stack and grown-list stores with scan and search state.
// ----------------------------------------------------------------------------
module rrgl_dp #(
	parameter int MAX_ROWS = rrgl_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rrgl_pkg::DEF_MAX_COLS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrgl_pkg::ctrl_cmd_t          cmd,
	output rrgl_pkg::dp_stat_t           stat,
	input  logic [rrgl_pkg::ROW_W-1:0]   row,
	input  logic [rrgl_pkg::COL_W-1:0]   col,
	input  logic                         in_object,
	input  logic [rrgl_pkg::RATIO_W-1:0] ratio_ch0,
	input  logic [rrgl_pkg::RATIO_W-1:0] ratio_ch1,
	input  logic [rrgl_pkg::RATIO_W-1:0] ratio_ch2,
	input  logic [rrgl_pkg::DIM_W-1:0]   tile_rows,
	input  logic [rrgl_pkg::DIM_W-1:0]   tile_cols,
	input  logic [rrgl_pkg::THR_W-1:0]   gradient_threshold,
	input  logic [rrgl_pkg::MIN_W-1:0]   min_segment_size,
	output logic [rrgl_pkg::LABEL_W-1:0] pixel_label,
	output logic [rrgl_pkg::LABEL_W-1:0] labels_issued,
	output logic [rrgl_pkg::LABEL_W-1:0] segments_kept
);

	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int AW    = RB + CB;
	localparam int NW    = AW + 1;
	localparam int DEPTH = 1 << AW;
	localparam int LW    = rrgl_pkg::LABEL_W;
	localparam int RTW   = rrgl_pkg::RATIO_W;
	localparam int PW    = rrgl_pkg::PIX_W;

	logic [PW-1:0] pix_mem [DEPTH];
	logic [LW-1:0] lbl_mem [DEPTH];
	logic          vis_mem [DEPTH];
	logic [AW-1:0] stk_mem [DEPTH];
	logic [AW-1:0] grw_mem [DEPTH];

	logic [PW-1:0] pix_rd;
	logic [LW-1:0] lbl_rd;
	logic          vis_rd;
	logic [AW-1:0] stk_rd;
	logic [AW-1:0] grw_rd;

	logic [RW-1:0]   rows_q, rows_c;
	logic [CW-1:0]   cols_q, cols_c;
	logic [RB-1:0]   sr_q;
	logic [CB-1:0]   sc_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   top_q;
	logic [AW-1:0]   nb_q;
	logic [AW-1:0]   nb_addr;
	logic            nb_ok;
	rrgl_pkg::dir_t  dir_q;
	logic [NW-1:0]   sp_q, gc_q, k_q;
	logic            sw_s1;
	logic            revert_q;
	logic [LW-1:0]   label_cnt_q, kept_q, cur_q, lbl_next, area;
	logic [3*RTW-1:0] seed_q;
	logic            ran_q, sel_q;
	logic            keep, close, in_inside, col_end;

	logic [AW-1:0] in_addr, scan_addr;
	logic [RB-1:0] tr;
	logic [CB-1:0] tc;

	logic          pix_re, lbl_re, lbl_we, vis_we, vis_wd, stk_we, grw_we, grw_re;
	logic [AW-1:0] pix_ra, lbl_ra, lbl_wa, vis_wa, stk_wa, grw_wa;
	logic [LW-1:0] lbl_wd;
	logic [AW-1:0] stk_wd;

	assign in_inside = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
	assign in_addr   = {RB'(row), CB'(col)};
	assign scan_addr = {sr_q, sc_q};
	assign tr        = top_q[AW-1:CB];
	assign tc        = top_q[CB-1:0];

	always_comb begin
		if (tile_rows == '0) rows_c = RW'(1);
		else if (32'(tile_rows) > MAX_ROWS) rows_c = RW'(MAX_ROWS);
		else rows_c = RW'(tile_rows);
		if (tile_cols == '0) cols_c = CW'(1);
		else if (32'(tile_cols) > MAX_COLS) cols_c = CW'(MAX_COLS);
		else cols_c = CW'(tile_cols);
	end

	always_comb begin
		unique case (dir_q)
			rrgl_pkg::DIR_DOWN: begin
				nb_ok   = (RW'(tr) + RW'(1)) < rows_q;
				nb_addr = {tr + RB'(1), tc};
			end
			rrgl_pkg::DIR_RIGHT: begin
				nb_ok   = (CW'(tc) + CW'(1)) < cols_q;
				nb_addr = {tr, tc + CB'(1)};
			end
			rrgl_pkg::DIR_UP: begin
				nb_ok   = (tr != '0);
				nb_addr = {tr - RB'(1), tc};
			end
			default: begin
				nb_ok   = (tc != '0);
				nb_addr = {tr, tc - CB'(1)};
			end
		endcase
	end

	assign close = (rrgl_pkg::abs_diff(seed_q[RTW-1:0], pix_rd[RTW-1:0]) < gradient_threshold)
		&& (rrgl_pkg::abs_diff(seed_q[2*RTW-1:RTW], pix_rd[2*RTW-1:RTW]) < gradient_threshold)
		&& (rrgl_pkg::abs_diff(seed_q[3*RTW-1:2*RTW], pix_rd[3*RTW-1:2*RTW])
			< gradient_threshold);

	assign lbl_next = (label_cnt_q == rrgl_pkg::SAT13) ? rrgl_pkg::SAT13 : label_cnt_q + LW'(1);
	assign area     = (32'(gc_q) > 32'(rrgl_pkg::SAT13)) ? rrgl_pkg::SAT13 : LW'(gc_q);
	assign keep     = (area >= min_segment_size);
	assign col_end  = (CW'(sc_q) + CW'(1)) == cols_q;

	assign stat.clr_last   = (clr_q == '1);
	assign stat.scan_seed  = pix_rd[PW-1] && (lbl_rd == '0);
	assign stat.scan_last  = col_end && ((RW'(sr_q) + RW'(1)) == rows_q);
	assign stat.nb_ok      = nb_ok;
	assign stat.join_ok    = !vis_rd && pix_rd[PW-1] && close;
	assign stat.dir_last   = (dir_q == rrgl_pkg::DIR_LEFT);
	assign stat.sp_one     = (sp_q == NW'(1));
	assign stat.sweep_done = (k_q == gc_q) && !sw_s1;

	assign pixel_label   = sel_q ? lbl_rd : '0;
	assign labels_issued = label_cnt_q;
	assign segments_kept = kept_q;

	always_comb begin
		pix_re = cmd.scan_rd || cmd.nb_rd;
		pix_ra = cmd.scan_rd ? scan_addr : nb_addr;
		lbl_re = cmd.read || cmd.scan_rd;
		lbl_ra = cmd.read ? in_addr : scan_addr;
		grw_re = cmd.sweep && (k_q != gc_q);

		lbl_we = 1'b0;
		lbl_wa = clr_q;
		lbl_wd = '0;
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 1'b0;
		stk_we = 1'b0;
		stk_wa = '0;
		stk_wd = scan_addr;
		grw_we = 1'b0;
		grw_wa = '0;
		if (cmd.clr_step) begin
			lbl_we = 1'b1;
			vis_we = 1'b1;
		end else if (cmd.seed) begin
			lbl_we = 1'b1;
			lbl_wa = scan_addr;
			lbl_wd = lbl_next;
			vis_we = 1'b1;
			vis_wa = scan_addr;
			vis_wd = 1'b1;
			stk_we = 1'b1;
			grw_we = 1'b1;
		end else if (cmd.grow) begin
			lbl_we = 1'b1;
			lbl_wa = nb_q;
			lbl_wd = cur_q;
			vis_we = 1'b1;
			vis_wa = nb_q;
			vis_wd = 1'b1;
			stk_we = 1'b1;
			stk_wa = sp_q[AW-1:0];
			stk_wd = nb_q;
			grw_we = 1'b1;
			grw_wa = gc_q[AW-1:0];
		end else if (cmd.sweep && sw_s1) begin
			lbl_we = revert_q;
			lbl_wa = grw_rd;
			vis_we = 1'b1;
			vis_wa = grw_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_inside)
			pix_mem[in_addr] <= {in_object, ratio_ch2, ratio_ch1, ratio_ch0};
		if (pix_re)
			pix_rd <= pix_mem[pix_ra];
	end

	always_ff @(posedge clk) begin
		if (lbl_we)
			lbl_mem[lbl_wa] <= lbl_wd;
		if (lbl_re)
			lbl_rd <= lbl_mem[lbl_ra];
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_wa] <= vis_wd;
		if (cmd.nb_rd)
			vis_rd <= vis_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		if (cmd.pop)
			stk_rd <= stk_mem[AW'(sp_q - NW'(2))];
	end

	always_ff @(posedge clk) begin
		if (grw_we)
			grw_mem[grw_wa] <= stk_wd;
		if (grw_re)
			grw_rd <= grw_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= '0;
			cols_q      <= '0;
			sr_q        <= '0;
			sc_q        <= '0;
			clr_q       <= '0;
			top_q       <= '0;
			nb_q        <= '0;
			dir_q       <= rrgl_pkg::DIR_DOWN;
			sp_q        <= '0;
			gc_q        <= '0;
			k_q         <= '0;
			sw_s1       <= 1'b0;
			revert_q    <= 1'b0;
			label_cnt_q <= '0;
			kept_q      <= '0;
			cur_q       <= '0;
			seed_q      <= '0;
			ran_q       <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (cmd.acc)
				sel_q <= cmd.read && in_inside && ran_q;
			if (cmd.run_start) begin
				rows_q      <= rows_c;
				cols_q      <= cols_c;
				sr_q        <= '0;
				sc_q        <= '0;
				clr_q       <= '0;
				label_cnt_q <= '0;
				kept_q      <= '0;
				ran_q       <= 1'b1;
			end
			if (cmd.clr_step)
				clr_q <= clr_q + AW'(1);
			if (cmd.scan_adv) begin
				if (col_end) begin
					sc_q <= '0;
					sr_q <= sr_q + RB'(1);
				end else begin
					sc_q <= sc_q + CB'(1);
				end
			end
			if (cmd.seed) begin
				label_cnt_q <= lbl_next;
				cur_q       <= lbl_next;
				top_q       <= scan_addr;
				seed_q      <= pix_rd[3*RTW-1:0];
				sp_q        <= NW'(1);
				gc_q        <= NW'(1);
				dir_q       <= rrgl_pkg::DIR_DOWN;
			end
			if (cmd.nb_rd)
				nb_q <= nb_addr;
			if (cmd.grow) begin
				top_q <= nb_q;
				sp_q  <= sp_q + NW'(1);
				gc_q  <= gc_q + NW'(1);
				dir_q <= rrgl_pkg::DIR_DOWN;
			end
			if (cmd.dir_next)
				dir_q <= rrgl_pkg::dir_t'(dir_q + 2'd1);
			if (cmd.pop)
				sp_q <= sp_q - NW'(1);
			if (cmd.pop_ld) begin
				top_q <= stk_rd;
				dir_q <= rrgl_pkg::DIR_DOWN;
			end
			if (cmd.fin) begin
				k_q      <= '0;
				sw_s1    <= 1'b0;
				revert_q <= !keep;
				if (keep && (kept_q != rrgl_pkg::SAT13))
					kept_q <= kept_q + LW'(1);
			end
			if (cmd.sweep) begin
				sw_s1 <= grw_re;
				if (grw_re)
					k_q <= k_q + NW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stack_within_grown: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= gc_q)
		else $error("search stack deeper than the grown list");
	a_pop_leaves_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (sp_q >= NW'(2)))
		else $error("pop issued with no entry below the top");
`endif

endmodule
